@@ sv/til_pkg.sv @@
// Package for the timed interval lookup block: widths, codes, controller states.
// No dependencies.
package til_pkg;
   localparam int MaxEntries = 1024;
   localparam int TagBits    = 16;
   localparam int StartBits  = 31;
   localparam logic [30:0] END_NEVER = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_FOUND   = 3'd0,
      ST_MISS    = 3'd1,
      ST_LOADED  = 3'd2,
      ST_FULL    = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LSRCH,   // load: binary search issue
      S_LSWAIT,  // load: search read returns
      S_SHIFT,   // load: read entry i-1
      S_SHWR,    // load: write entry i
      S_LWR,     // load: write new entry
      S_QRD,     // query: read entry a
      S_QCHK,    // query: check a with a+1
      S_QSRCH,
      S_QSWAIT,
      S_OUT
   } state_type;
endpackage

@@ sv/til_if.sv @@
// Request, response and register-write channel interfaces.
// Depends on til_pkg for widths.
interface til_req_if import til_pkg::*; #(parameter int TAG_BITS = TagBits);
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [30:0]         entry_start;
   logic [TAG_BITS-1:0] entry_tag;
   logic [31:0]         query_time;
   modport source (output valid, req_type, entry_start, entry_tag, query_time, input ready);
   modport sink   (input valid, req_type, entry_start, entry_tag, query_time, output ready);
endinterface

interface til_rsp_if #(parameter int TAG_BITS = 16, parameter int IDX_BITS = 10);
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [IDX_BITS-1:0] hit_index;
   logic [TAG_BITS-1:0] hit_tag;
   logic [30:0]         hit_start;
   logic [30:0]         hit_end;
   modport source (output valid, status, hit_index, hit_tag, hit_start, hit_end, input ready);
   modport sink   (input valid, status, hit_index, hit_tag, hit_start, hit_end, output ready);
endinterface

interface til_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ sv/timed_interval_lookup.sv @@
// Timed interval lookup: sorted table of (start, tag) entries with cursor lookup.
// Query: the cursor entry is checked first, then the entry after the cursor,
// else a binary search (up to 11 steps at 1024 entries) plus a final check.
// Load: binary search for the slot, each later entry shifted up, new entry written.
// Clear, full-table load and empty-table query go straight to the response.
// One request in flight.
// Reset (synchronous, active high) empties the table, zeroes cursor and adjust;
// the entry memory itself is not cleared, the fill count guards it.
module timed_interval_lookup import til_pkg::*; #(
   parameter int MAX_ENTRIES = MaxEntries,
   parameter int TAG_BITS    = TagBits,
   localparam int IB = $clog2(MAX_ENTRIES),
   localparam int CB = $clog2(MAX_ENTRIES + 1)
) (
   input logic clock,
   input logic reset,
   til_req_if.sink   req,
   til_rsp_if.source rsp,
   til_csr_if.sink   csr
);
   localparam int WB = StartBits + TAG_BITS;

   // single-port entry memory {start, tag}, read data registered
   logic [WB-1:0] mem [MAX_ENTRIES];
   logic [WB-1:0] rd_ff;
   logic [IB-1:0] addr;
   logic          we;
   logic [WB-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   state_type     state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [IB-1:0] cursor_ff, cursor_in;
   logic [31:0]   adjust_ff;
   logic [30:0]   lstart_ff, lstart_in;
   logic [TAG_BITS-1:0] ltag_ff, ltag_in;
   logic [31:0]   t_ff, t_in;
   // search bounds, lo/hi may equal count so they carry CB bits
   logic [CB-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [CB-1:0] i_ff, i_in;      // shift index / query candidate
   logic          second_ff, second_in; // query: second check (cursor+1 or after search)
   logic          phase_ff, phase_in;   // qchk: 0 read a+1, 1 decide
   logic [WB-1:0] cur_ff, cur_in;       // entry a contents
   status_type    st_ff, st_in;
   logic [IB-1:0] oidx_ff, oidx_in;
   logic [TAG_BITS-1:0] otag_ff, otag_in;
   logic [30:0]   os_ff, os_in, oe_ff, oe_in;

   logic [30:0] rd_start, cur_start, nxt_end;
   logic        last;
   assign rd_start  = rd_ff[WB-1 -: StartBits];
   assign cur_start = cur_ff[WB-1 -: StartBits];
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last = (i_ff + 1'b1) >= count_ff;
   assign nxt_end = last ? END_NEVER : rd_start;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid     = (state_ff == S_OUT);
   assign rsp.status    = st_ff;
   assign rsp.hit_index = oidx_ff;
   assign rsp.hit_tag   = otag_ff;
   assign rsp.hit_start = os_ff;
   assign rsp.hit_end   = oe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         adjust_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         if (csr.valid) adjust_ff <= csr.data;
      end
      lstart_ff <= lstart_in;  ltag_ff <= ltag_in;
      t_ff <= t_in;  lo_ff <= lo_in;  hi_ff <= hi_in;  i_ff <= i_in;
      second_ff <= second_in;  phase_ff <= phase_in;  cur_ff <= cur_in;
      st_ff <= st_in;  oidx_ff <= oidx_in;  otag_ff <= otag_in;
      os_ff <= os_in;  oe_ff <= oe_in;
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  cursor_in = cursor_ff;
      lstart_in = lstart_ff;  ltag_in = ltag_ff;
      t_in = t_ff;  lo_in = lo_ff;  hi_in = hi_ff;  i_in = i_ff;
      second_in = second_ff;  phase_in = phase_ff;  cur_in = cur_ff;
      st_in = st_ff;  oidx_in = oidx_ff;  otag_in = otag_ff;
      os_in = os_ff;  oe_in = oe_ff;
      addr = mid[IB-1:0];  we = 1'b0;  wdata = {lstart_ff, ltag_ff};
      unique case (state_ff)
         S_IDLE: if (req.valid) begin
            lstart_in = req.entry_start;  ltag_in = req.entry_tag;
            t_in = req.query_time - adjust_ff;
            lo_in = '0;  hi_in = count_ff;
            oidx_in = '0;  otag_in = '0;  os_in = '0;  oe_in = '0;
            unique case (req.req_type)
               REQ_LOAD: begin
                  if (count_ff >= CB'(MAX_ENTRIES)) begin
                     st_in = ST_FULL;  state_in = S_OUT;
                  end else state_in = S_LSRCH;
               end
               REQ_CLEAR: begin
                  count_in = '0;  cursor_in = '0;
                  st_in = ST_CLEARED;  state_in = S_OUT;
               end
               REQ_QUERY: begin
                  if (count_ff == '0) begin
                     st_in = ST_MISS;  state_in = S_OUT;
                  end else begin
                     i_in = (CB'(cursor_ff) < count_ff) ? CB'(cursor_ff) : '0;
                     second_in = 1'b0;  state_in = S_QRD;
                  end
               end
               default: ;  // unknown: dropped without result
            endcase
         end
         S_LSRCH, S_QSRCH: begin
            if (lo_ff < hi_ff) begin
               addr = mid[IB-1:0];
               state_in = (state_ff == S_LSRCH) ? S_LSWAIT : S_QSWAIT;
            end else if (state_ff == S_LSRCH) begin
               i_in = count_ff;  state_in = S_SHIFT;
            end else if (lo_ff == '0) begin
               st_in = ST_MISS;  state_in = S_OUT;
            end else begin
               i_in = lo_ff - 1'b1;  second_in = 1'b1;  state_in = S_QRD;
            end
         end
         S_LSWAIT, S_QSWAIT: begin
            if ({1'b0, rd_start} <= ((state_ff == S_LSWAIT) ? {1'b0, lstart_ff} : t_ff))
               lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = (state_ff == S_LSWAIT) ? S_LSRCH : S_QSRCH;
         end
         S_SHIFT: begin
            if (i_ff > lo_ff) begin
               addr = IB'(i_ff - 1'b1);  state_in = S_SHWR;
            end else state_in = S_LWR;
         end
         S_SHWR: begin
            addr = i_ff[IB-1:0];  we = 1'b1;  wdata = rd_ff;
            i_in = i_ff - 1'b1;  state_in = S_SHIFT;
         end
         S_LWR: begin
            addr = lo_ff[IB-1:0];  we = 1'b1;
            count_in = count_ff + 1'b1;  cursor_in = '0;
            st_in = ST_LOADED;  state_in = S_OUT;
         end
         S_QRD: begin
            addr = i_ff[IB-1:0];  phase_in = 1'b0;  state_in = S_QCHK;
         end
         S_QCHK: begin
            if (!phase_ff) begin
               cur_in = rd_ff;  phase_in = 1'b1;
               addr = IB'(i_ff + 1'b1);   // value unused when last
            end else begin
               // rd_ff holds entry a+1 (when it exists)
               if ({1'b0, cur_start} <= t_ff && t_ff < {1'b0, nxt_end}) begin
                  st_in = ST_FOUND;  cursor_in = i_ff[IB-1:0];
                  oidx_in = i_ff[IB-1:0];  otag_in = cur_ff[TAG_BITS-1:0];
                  os_in = cur_start;  oe_in = nxt_end;  state_in = S_OUT;
               end else if (second_ff) begin
                  // after search: miss; or cursor+1 check failed
                  if (lo_ff == '0 && hi_ff == count_ff) begin
                     state_in = S_QSRCH;  // pre-search cursor+1 failed
                  end else begin
                     st_in = ST_MISS;  state_in = S_OUT;
                  end
               end else if (t_ff >= {1'b0, nxt_end} && !last) begin
                  i_in = i_ff + 1'b1;  second_in = 1'b1;
                  lo_in = '0;  hi_in = count_ff;  state_in = S_QRD;
               end else state_in = S_QSRCH;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
endmodule
